// ----- rtl/core/noek_pkg.sv -----
// Shared types, round constants and round functions of the NOEKEON cipher pipeline.
package noek_pkg;

  localparam int unsigned RoundCountDef = 16;
  localparam int unsigned RoundCountMax = 16;

  typedef logic [3:0][31:0] noek_words_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        mode;
  } noek_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } noek_out_t;

  typedef struct packed {
    logic        valid;
    logic        mode;
    noek_words_t w;
  } noek_stage_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } noek_cfg_e;

  localparam logic [7:0] RoundConst [RoundCountMax+1] = '{
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A, 8'h2F,
    8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  function automatic logic [31:0] mix8_f(input logic [31:0] t);
    mix8_f = t ^ {t[7:0], t[31:8]} ^ {t[23:0], t[31:24]};
  endfunction

  function automatic noek_words_t theta_f(input noek_words_t w, input noek_words_t k);
    logic [31:0] t;
    noek_words_t r;
    r = w;
    t = mix8_f(r[0] ^ r[2]);
    r[1] = r[1] ^ t;
    r[3] = r[3] ^ t;
    r = r ^ k;
    t = mix8_f(r[1] ^ r[3]);
    r[0] = r[0] ^ t;
    r[2] = r[2] ^ t;
    theta_f = r;
  endfunction

  function automatic noek_words_t pgp_f(input noek_words_t w);
    logic [31:0] t;
    noek_words_t r;
    r = w;
    r[1] = {r[1][30:0], r[1][31]};
    r[2] = {r[2][26:0], r[2][31:27]};
    r[3] = {r[3][29:0], r[3][31:30]};
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    t = r[0];
    r[0] = r[3];
    r[3] = t;
    r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    r[1] = {r[1][0], r[1][31:1]};
    r[2] = {r[2][4:0], r[2][31:5]};
    r[3] = {r[3][1:0], r[3][31:2]};
    pgp_f = r;
  endfunction

endpackage

// ----- rtl/core/noek_round.sv -----
// One registered NOEKEON round stage serving both encryption and decryption.
module noek_round #(
  parameter int unsigned ROUND_COUNT = noek_pkg::RoundCountDef,
  parameter int unsigned ROUND_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  noek_pkg::noek_stage_t stage_i,
  input  noek_pkg::noek_words_t enc_key_i,
  input  noek_pkg::noek_words_t dec_key_i,
  output noek_pkg::noek_stage_t stage_o
);
  import noek_pkg::*;

  localparam logic [7:0] EncRc = RoundConst[ROUND_IDX];
  localparam logic [7:0] DecRc = RoundConst[ROUND_COUNT - ROUND_IDX];

  noek_words_t mixed;
  noek_words_t words_d, words_q;
  logic        mode_q;
  logic        valid_q;

  always_comb begin
    mixed = stage_i.w;
    if (!stage_i.mode) begin
      mixed[0] = mixed[0] ^ {24'd0, EncRc};
      mixed    = theta_f(mixed, enc_key_i);
    end else begin
      mixed    = theta_f(mixed, dec_key_i);
      mixed[0] = mixed[0] ^ {24'd0, DecRc};
    end
    words_d = pgp_f(mixed);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
    mode_q  <= stage_i.mode;
  end

  assign stage_o = '{valid: valid_q, mode: mode_q, w: words_q};

endmodule

// ----- rtl/core/noek_final.sv -----
// Final NOEKEON Theta stage with the registered result port.
module noek_final #(
  parameter int unsigned ROUND_COUNT = noek_pkg::RoundCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  noek_pkg::noek_stage_t stage_i,
  input  noek_pkg::noek_words_t enc_key_i,
  input  noek_pkg::noek_words_t dec_key_i,
  output logic                  out_valid_o,
  output noek_pkg::noek_out_t   out_o
);
  import noek_pkg::*;

  localparam logic [7:0] EncRc = RoundConst[ROUND_COUNT];
  localparam logic [7:0] DecRc = RoundConst[0];

  noek_words_t words_d;
  noek_out_t   out_q;
  logic        valid_q;

  always_comb begin
    words_d = stage_i.w;
    if (!stage_i.mode) begin
      words_d[0] = words_d[0] ^ {24'd0, EncRc};
      words_d    = theta_f(words_d, enc_key_i);
    end else begin
      words_d    = theta_f(words_d, dec_key_i);
      words_d[0] = words_d[0] ^ {24'd0, DecRc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= '{out_high: {words_d[0], words_d[1]}, out_low: {words_d[2], words_d[3]}};
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

// ----- rtl/core/noekeon_block_cipher.sv -----
// Top level of the pipelined NOEKEON direct-key block cipher.
//
//   Port group   Direction  Handshake                 Beat
//   start/in_i   in         start && !busy            block_high, block_low, mode
//   out_o        out        out_valid_o (one cycle)   out_high, out_low
//   cfg          in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One block is taken every cycle; busy stays low.
// There is one register per round and one register after the final Theta, the first one
// loaded at the edge that takes the block. The result is on the ports once the final
// register holds it, with out_valid_o high.
// Reset clears the key to zero and empties the pipeline, dropping any block in flight.
// The receiver cannot stall, so every beat moves down the pipeline each cycle.
module noekeon_block_cipher #(
  parameter int unsigned ROUND_COUNT = noek_pkg::RoundCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  noek_pkg::noek_in_t in_i,
  output logic               out_valid_o,
  output noek_pkg::noek_out_t out_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import noek_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  noek_words_t enc_key, dec_key;
  noek_stage_t stage [ROUND_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (noek_cfg_e'(cfg_idx_i))
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    enc_key[0] = key_high_q[63:32];
    enc_key[1] = key_high_q[31:0];
    enc_key[2] = key_low_q[63:32];
    enc_key[3] = key_low_q[31:0];
    dec_key    = theta_f(enc_key, '0);
  end

  assign busy = 1'b0;

  assign stage[0].valid = start && !busy;
  assign stage[0].mode  = in_i.mode;
  assign stage[0].w[0]  = in_i.block_high[63:32];
  assign stage[0].w[1]  = in_i.block_high[31:0];
  assign stage[0].w[2]  = in_i.block_low[63:32];
  assign stage[0].w[3]  = in_i.block_low[31:0];

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    noek_round #(
      .ROUND_COUNT(ROUND_COUNT),
      .ROUND_IDX  (i)
    ) u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .stage_i  (stage[i]),
      .enc_key_i(enc_key),
      .dec_key_i(dec_key),
      .stage_o  (stage[i+1])
    );
  end

  noek_final #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_final (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage[ROUND_COUNT]),
    .enc_key_i  (enc_key),
    .dec_key_i  (dec_key),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

endmodule

// ----- rtl/core/noek_chk.sv -----
// Port-level checker for the NOEKEON cipher pipeline and its bind statement.
module noek_chk #(
  parameter int unsigned ROUND_COUNT = noek_pkg::RoundCountDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic out_valid_o
);
  localparam int unsigned Latency = ROUND_COUNT + 1;
  localparam int unsigned AgeW    = $clog2(Latency + 1);

  logic [AgeW-1:0] age_q, age_d;
  logic            accept;

  assign accept = start && !busy;
  assign age_d  = (age_q == AgeW'(Latency)) ? age_q : age_q + AgeW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else begin
      age_q <= age_d;
    end
  end

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the pipeline never stalls");

  a_out_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, Latency))
    else $error("result beat without a matching input beat");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q == AgeW'(Latency)) && $past(accept, Latency) |-> out_valid_o)
    else $error("input beat produced no result beat");

endmodule

bind noekeon_block_cipher noek_chk #(
  .ROUND_COUNT(ROUND_COUNT)
) u_noek_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .out_valid_o(out_valid_o)
);

// ----- test/noekeon_block_cipher_test.sv -----
// Self-checking testbench for the pipelined NOEKEON block cipher with random traffic.
`timescale 1ns / 1ps

module noekeon_block_cipher_test;
  import noek_pkg::*;

  localparam int unsigned ROUNDS  = RoundCountDef;
  localparam int unsigned LATENCY = ROUNDS + 1;
  localparam bit [0:16][7:0] ROUND_CONSTS = {
    8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8, 8'hAB, 8'h4D, 8'h9A, 8'h2F,
    8'h5E, 8'hBC, 8'h63, 8'hC6, 8'h97, 8'h35, 8'h6A, 8'hD4
  };

  typedef bit [3:0][31:0] quad_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  noek_in_t   in_i = '0;
  logic       out_valid_o;
  noek_out_t  out_o;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  bit [63:0]  key_high_copy = '0;
  bit [63:0]  key_low_copy = '0;
  noek_out_t  due_blocks[$];
  noek_out_t  last_result;
  noek_out_t  want;
  int         fault_count = 0;

  noekeon_block_cipher #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit [31:0] rotl(bit [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic bit [31:0] rotr(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic quad_t theta_mix(quad_t w, quad_t k);
    bit [31:0] t;
    t = w[0] ^ w[2];
    t = t ^ rotr(t, 8) ^ rotl(t, 8);
    w[1] = w[1] ^ t;
    w[3] = w[3] ^ t;
    w = w ^ k;
    t = w[1] ^ w[3];
    t = t ^ rotr(t, 8) ^ rotl(t, 8);
    w[0] = w[0] ^ t;
    w[2] = w[2] ^ t;
    return w;
  endfunction

  function automatic quad_t pi_gamma_pi(quad_t w);
    bit [31:0] t;
    w[1] = rotl(w[1], 1);
    w[2] = rotl(w[2], 5);
    w[3] = rotl(w[3], 2);
    w[1] = w[1] ^ ~(w[3] | w[2]);
    w[0] = w[0] ^ (w[2] & w[1]);
    t = w[0];
    w[0] = w[3];
    w[3] = t;
    w[2] = w[2] ^ w[0] ^ w[1] ^ w[3];
    w[1] = w[1] ^ ~(w[3] | w[2]);
    w[0] = w[0] ^ (w[2] & w[1]);
    w[1] = rotr(w[1], 1);
    w[2] = rotr(w[2], 5);
    w[3] = rotr(w[3], 2);
    return w;
  endfunction

  function automatic noek_out_t noekeon_predict(noek_in_t item);
    quad_t     s;
    quad_t     k;
    noek_out_t res;
    s[0] = item.block_high[63:32];
    s[1] = item.block_high[31:0];
    s[2] = item.block_low[63:32];
    s[3] = item.block_low[31:0];
    k[0] = key_high_copy[63:32];
    k[1] = key_high_copy[31:0];
    k[2] = key_low_copy[63:32];
    k[3] = key_low_copy[31:0];
    if (!item.mode) begin
      for (int r = 0; r < ROUNDS; r++) begin
        s[0] = s[0] ^ ROUND_CONSTS[r];
        s = theta_mix(s, k);
        s = pi_gamma_pi(s);
      end
      s[0] = s[0] ^ ROUND_CONSTS[ROUNDS];
      s = theta_mix(s, k);
    end else begin
      k = theta_mix(k, '0);
      for (int r = ROUNDS; r > 0; r--) begin
        s = theta_mix(s, k);
        s[0] = s[0] ^ ROUND_CONSTS[r];
        s = pi_gamma_pi(s);
      end
      s = theta_mix(s, k);
      s[0] = s[0] ^ ROUND_CONSTS[0];
    end
    res.out_high = {s[0], s[1]};
    res.out_low  = {s[2], s[3]};
    return res;
  endfunction

  task automatic note_error(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    fault_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (due_blocks.size() == 0) begin
        note_error($sformatf("result %h with no block due", out_o));
      end else begin
        want = due_blocks.pop_front();
        if (out_o.out_high !== want.out_high) begin
          note_error($sformatf("out_high got %h want %h", out_o.out_high, want.out_high));
        end
        if (out_o.out_low !== want.out_low) begin
          note_error($sformatf("out_low got %h want %h", out_o.out_low, want.out_low));
        end
      end
    end
  end

  task automatic send_block(input noek_in_t item);
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
    last_result = noekeon_predict(item);
    due_blocks.push_back(last_result);
  endtask

  task automatic send_parts(input logic [63:0] hi, input logic [63:0] lo, input logic mode);
    noek_in_t item;
    item.block_high = hi;
    item.block_low  = lo;
    item.mode       = mode;
    send_block(item);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (due_blocks.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 3) @(posedge clk_i);
    if (due_blocks.size() != 0) begin
      note_error($sformatf("%0d results never arrived", due_blocks.size()));
      due_blocks.delete();
    end
  endtask

  task automatic write_reg(input noek_cfg_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_high_copy = data;
    else key_low_copy = data;
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LOW, lo);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_reset_key();
    send_parts('0, '0, 1'b0);
    send_parts('0, '0, 1'b1);
    send_parts('1, '1, 1'b0);
    send_parts('1, '1, 1'b1);
    settle();
  endtask

  task automatic test_corner_keys();
    noek_out_t ct;
    load_key('1, '1);
    send_parts('0, '0, 1'b0);
    send_parts('0, '0, 1'b1);
    send_parts('1, '1, 1'b0);
    send_parts('1, '1, 1'b1);
    settle();
    load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_parts({32{2'b10}}, {32{2'b01}}, 1'b0);
    send_parts({32{2'b01}}, {32{2'b10}}, 1'b1);
    send_parts(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0);
    ct = last_result;
    send_parts(ct.out_high, ct.out_low, 1'b1);
    settle();
    write_reg(CFG_KEY_LOW, '0);
    send_parts(64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0, 1'b0);
    ct = last_result;
    send_parts(ct.out_high, ct.out_low, 1'b1);
    hold_off(1);
    send_parts('0, '1, 1'b0);
    settle();
  endtask

  task automatic random_burst_phase(input int items, input bit pause_midway);
    int sent;
    int burst;
    logic mode;
    sent = 0;
    while (sent < items) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < items; b++) begin
        mode = $urandom_range(0, 1);
        if (mode && $urandom_range(0, 3) == 0) begin
          send_parts(last_result.out_high, last_result.out_low, 1'b1);
        end else begin
          send_parts(rand_half(), rand_half(), mode);
        end
        sent++;
        if (pause_midway && sent == items / 2) begin
          settle();
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        hold_off($urandom_range(1, 2 * LATENCY));
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_burst_phase(250, 1'b1);
    load_key('0, '1);
    random_burst_phase(200, 1'b0);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_burst_phase(250, 1'b0);
    load_key('1, '0);
    random_burst_phase(200, 1'b0);
    write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
    random_burst_phase(200, 1'b0);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_burst_phase(200, 1'b0);
    write_reg(CFG_KEY_LOW, {$urandom, $urandom});
    random_burst_phase(200, 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_corner_keys();
    test_random_traffic();
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
